// File: hdl/wsa_pkg.sv
// shared types and constants for the wheel speed to speed/angle unit
`timescale 1ns / 1ps

package wsa_pkg;

  localparam int unsigned SPEED_BITS = 10;
  localparam int unsigned ANGLE_BITS = 9;
  localparam int unsigned M_DATA_W   = 24;

  localparam logic [9:0] SPEED_MAX   = 10'd1023;
  localparam logic [9:0] FULL_TURN   = 10'd360;
  localparam logic [9:0] ANGLE_FWD   = 10'd90;
  localparam logic [9:0] ANGLE_HALF  = 10'd180;
  localparam logic [9:0] ANGLE_BACK  = 10'd270;
  localparam logic [9:0] ANGLE_WRAP  = 10'd540;

  // motion class of one request
  typedef enum logic [1:0] {
    KIND_FWD   = 2'd0,
    KIND_BACK  = 2'd1,
    KIND_LEFT  = 2'd2,
    KIND_RIGHT = 2'd3
  } kind_t;

  // side data that rides along the divider chain
  typedef struct packed {
    kind_t            kind;
    logic             neg_term;
    logic             zero_den;
    logic [SPEED_BITS-1:0] speed;
  } info_t;

endpackage

// File: hdl/wsa_prep.sv
// input decode: magnitudes, speed, motion class, dividend and divisor
`timescale 1ns / 1ps

module wsa_prep #(
  parameter int unsigned WHEEL_BITS = 16,
  parameter int unsigned NUM_W      = 22,
  parameter int unsigned DEN_W      = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [WHEEL_BITS-1:0] left_speed,
  input  logic [WHEEL_BITS-1:0] right_speed,
  output logic                  out_valid,
  output logic [NUM_W-1:0]      out_num,
  output logic [DEN_W-1:0]      out_den,
  output wsa_pkg::info_t        out_info
);

  localparam int unsigned W    = WHEEL_BITS;
  localparam int unsigned SC_W = (W > 10) ? W : 10;

  logic [W-1:0]    mag_l, mag_r, mx, mag_a;
  logic [W:0]      diff, mag_d, sum;
  logic [W-1:0]    half;
  logic [SC_W-1:0] half_x;
  logic [DEN_W-1:0] den;
  wsa_pkg::info_t  info;

  // stage 1 registers
  logic             v1;
  logic [W-1:0]     a1;
  logic [DEN_W-1:0] den1;
  wsa_pkg::info_t   info1;

  always_comb begin
    mag_l = left_speed[W-1] ? (~left_speed + W'(1)) : left_speed;
    mag_r = right_speed[W-1] ? (~right_speed + W'(1)) : right_speed;
    diff  = {right_speed[W-1], right_speed} - {left_speed[W-1], left_speed};
    mag_d = diff[W] ? (~diff + (W+1)'(1)) : diff;
    mx    = (mag_l > mag_r) ? mag_l : mag_r;
    sum   = {1'b0, mag_l} + {1'b0, mag_r};
    half  = sum[W:1];
    half_x = SC_W'(half);

    info.neg_term = diff[W];
    if (half_x > SC_W'(wsa_pkg::SPEED_MAX)) begin
      info.speed = wsa_pkg::SPEED_MAX;
    end else begin
      info.speed = half_x[9:0];
    end

    case ({left_speed[W-1], right_speed[W-1]})
      2'b00: begin
        info.kind = wsa_pkg::KIND_FWD;
        mag_a     = mag_d[W-1:0];
        den       = {mx, 1'b0};
      end
      2'b11: begin
        info.kind = wsa_pkg::KIND_BACK;
        mag_a     = mag_d[W-1:0];
        den       = {mx, 1'b0};
      end
      2'b01: begin
        info.kind = wsa_pkg::KIND_LEFT;
        mag_a     = mag_r;
        den       = {1'b0, mag_l};
      end
      default: begin
        info.kind = wsa_pkg::KIND_RIGHT;
        mag_a     = mag_l;
        den       = {1'b0, mag_r};
      end
    endcase
    // both wheels stopped, or a pivot against a stopped wheel
    info.zero_den = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // 90 * a as shifts and adds
  always_ff @(posedge clk) begin
    if (en) begin
      a1       <= mag_a;
      den1     <= den;
      info1    <= info;
      out_num  <= NUM_W'({a1, 6'b0}) + NUM_W'({a1, 4'b0}) + NUM_W'({a1, 3'b0})
                + NUM_W'({a1, 1'b0});
      out_den  <= den1;
      out_info <= info1;
    end
  end

endmodule

// File: hdl/wsa_cell.sv
// one restoring division cell: one quotient bit, quotient kept modulo 360
`timescale 1ns / 1ps

module wsa_cell #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [8:0]       in_qm,
  input  wsa_pkg::info_t   in_info,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_num,
  output logic [DEN_W-1:0] out_den,
  output logic [DEN_W-1:0] out_rem,
  output logic [8:0]       out_qm,
  output wsa_pkg::info_t   out_info
);

  logic [DEN_W:0]   trial, sub;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [9:0]       m2;
  logic [8:0]       qm_next;

  always_comb begin
    trial    = {in_rem, in_num[NUM_W-1]};
    ge       = (trial >= {1'b0, in_den});
    sub      = trial - {1'b0, in_den};
    rem_next = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
    // running quotient modulo a full turn
    m2       = {in_qm, ge};
    if (m2 >= wsa_pkg::FULL_TURN) begin
      m2 = m2 - wsa_pkg::FULL_TURN;
    end
    qm_next  = m2[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num  <= {in_num[NUM_W-2:0], 1'b0};
      out_den  <= in_den;
      out_rem  <= rem_next;
      out_qm   <= qm_next;
      out_info <= in_info;
    end
  end

endmodule

// File: hdl/wsa_out.sv
// heading assembly, output register and skid register
`timescale 1ns / 1ps

module wsa_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [8:0]                     in_qm,
  input  wsa_pkg::info_t                 in_info,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [wsa_pkg::M_DATA_W-1:0]   m_tdata,   // drive_speed[9:0], heading_angle[18:10]
  output logic                           skid_full
);

  logic [9:0] qx, angle;
  logic [wsa_pkg::M_DATA_W-1:0] word, skid;
  logic out_free;

  always_comb begin
    qx = {1'b0, in_qm};
    if (in_info.zero_den) begin
      angle = wsa_pkg::ANGLE_FWD;
    end else begin
      case (in_info.kind)
        wsa_pkg::KIND_FWD: begin
          angle = in_info.neg_term ? (wsa_pkg::ANGLE_FWD + qx) : (wsa_pkg::ANGLE_FWD - qx);
        end
        wsa_pkg::KIND_BACK: begin
          angle = in_info.neg_term ? (wsa_pkg::ANGLE_BACK + qx) : (wsa_pkg::ANGLE_BACK - qx);
        end
        wsa_pkg::KIND_LEFT: begin
          angle = (qx <= wsa_pkg::ANGLE_HALF) ? (wsa_pkg::ANGLE_HALF - qx)
                                               : (wsa_pkg::ANGLE_WRAP - qx);
        end
        default: begin
          angle = qx;
        end
      endcase
    end
    word = {5'b0, angle[8:0], in_info.speed};
  end

  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        m_tvalid  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        m_tvalid  <= in_valid;
      end
    end else if (in_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_full ? skid : word;
    end
    if (~out_free && in_valid) begin
      skid <= word;
    end
  end

endmodule

// File: hdl/wheel_speeds_to_speed_angle_unit.sv
// top level: wheel speeds to drive speed and heading angle
`timescale 1ns / 1ps

// usage
//   slave side (s_tvalid/s_tready/s_tdata) takes one request per cycle while s_tready is
//   high: the signed left and right wheel speeds, each WHEEL_BITS wide
//   master side (m_tvalid/m_tready/m_tdata) gives one result per request, in order:
//   drive speed (mean absolute speed, saturated at 1023) and heading in 0..359
//   throughput: one request per cycle while no result waits in the skid register
//   path from acceptance to m_tvalid: the two decode stages, the row of
//   WHEEL_BITS + 6 divider cells (one quotient bit each) and the output register
//   reset: rst (synchronous) empties every stage, the output and the skid register
//   stall: while m_tready is low the chain keeps moving until one result is parked
//   in the skid register; then s_tready drops and the whole chain holds its items
//   until the receiver takes the waiting result
module wheel_speeds_to_speed_angle_unit #(
  parameter int unsigned WHEEL_BITS = 16,
  localparam int unsigned S_DATA_W = ((2 * WHEEL_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [S_DATA_W-1:0]           s_tdata,   // left_speed, right_speed
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wsa_pkg::M_DATA_W-1:0]  m_tdata    // drive_speed[9:0], heading_angle[18:10]
);

  // dividend 90*|a| stays below 2^(WHEEL_BITS+6); divisor up to 2*max magnitude
  localparam int unsigned NUM_W = WHEEL_BITS + 6;
  localparam int unsigned DEN_W = WHEEL_BITS + 1;
  localparam int unsigned NCELL = NUM_W;

  logic en;
  logic skid_full;

  // chain taps, index 0 feeds the first cell
  logic             c_valid [0:NCELL];
  logic [NUM_W-1:0] c_num   [0:NCELL];
  logic [DEN_W-1:0] c_den   [0:NCELL];
  logic [DEN_W-1:0] c_rem   [0:NCELL];
  logic [8:0]       c_qm    [0:NCELL];
  wsa_pkg::info_t   c_info  [0:NCELL];

  // the whole chain advances together unless a result is parked in the skid
  assign en       = ~skid_full;
  assign s_tready = en;

  wsa_prep #(
    .WHEEL_BITS (WHEEL_BITS),
    .NUM_W      (NUM_W),
    .DEN_W      (DEN_W)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .left_speed  (s_tdata[WHEEL_BITS-1:0]),
    .right_speed (s_tdata[2*WHEEL_BITS-1:WHEEL_BITS]),
    .out_valid   (c_valid[0]),
    .out_num     (c_num[0]),
    .out_den     (c_den[0]),
    .out_info    (c_info[0])
  );

  // partial remainder and quotient residue start at zero
  assign c_rem[0] = '0;
  assign c_qm[0]  = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    wsa_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_valid[i]),
      .in_num    (c_num[i]),
      .in_den    (c_den[i]),
      .in_rem    (c_rem[i]),
      .in_qm     (c_qm[i]),
      .in_info   (c_info[i]),
      .out_valid (c_valid[i+1]),
      .out_num   (c_num[i+1]),
      .out_den   (c_den[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_qm    (c_qm[i+1]),
      .out_info  (c_info[i+1])
    );
  end

  // last cell hands its item over only on a cycle the chain moves
  wsa_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[NCELL] & en),
    .in_qm     (c_qm[NCELL]),
    .in_info   (c_info[NCELL]),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .skid_full (skid_full)
  );

endmodule

// File: bench/motion_checker.sv
// checker: predicts speed and heading for every accepted request and compares results
`timescale 1ns / 1ps

module motion_checker #(
  parameter int unsigned WHEEL_BITS = 16,
  parameter int unsigned S_DATA_W   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [S_DATA_W-1:0]          s_tdata,   // left_speed, right_speed
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [wsa_pkg::M_DATA_W-1:0] m_tdata,   // drive_speed, heading_angle
  output int                           fail_count,
  output int                           pending
);

  localparam int unsigned SPD_W = wsa_pkg::SPEED_BITS;
  localparam int unsigned ANG_W = wsa_pkg::ANGLE_BITS;

  localparam longint SPEED_CAP = longint'(wsa_pkg::SPEED_MAX);
  localparam longint TURN      = longint'(wsa_pkg::FULL_TURN);
  localparam longint QUARTER   = longint'(wsa_pkg::ANGLE_FWD);
  localparam longint HALF      = longint'(wsa_pkg::ANGLE_HALF);
  localparam longint BACK      = longint'(wsa_pkg::ANGLE_BACK);

  typedef struct packed {
    logic [ANG_W-1:0] heading_angle;
    logic [SPD_W-1:0] drive_speed;
  } motion_t;

  motion_t motion_due[$];
  int      errs = 0;

  function automatic motion_t predict_motion(logic signed [WHEEL_BITS-1:0] left,
                                             logic signed [WHEEL_BITS-1:0] right);
    longint          l, r, al, ar, mx, speed, angle;
    wsa_pkg::kind_t  kind;
    motion_t         res;
    l  = left;
    r  = right;
    al = (l < 0) ? -l : l;
    ar = (r < 0) ? -r : r;
    if (l == 0 && r == 0) begin
      res.drive_speed   = '0;
      res.heading_angle = ANG_W'(QUARTER);
      return res;
    end
    speed = (al + ar) / 2;
    if (speed > SPEED_CAP) speed = SPEED_CAP;
    mx = (al > ar) ? al : ar;
    if (l >= 0 && r >= 0) kind = wsa_pkg::KIND_FWD;
    else if (l < 0 && r < 0) kind = wsa_pkg::KIND_BACK;
    else if (l >= 0) kind = wsa_pkg::KIND_LEFT;
    else kind = wsa_pkg::KIND_RIGHT;
    // zero divisor in a pivot counts as ratio one
    case (kind)
      wsa_pkg::KIND_FWD:  angle = QUARTER - (QUARTER * (r - l)) / (2 * mx);
      wsa_pkg::KIND_BACK: angle = BACK - (QUARTER * (r - l)) / (2 * mx);
      wsa_pkg::KIND_LEFT: angle = HALF - ((al == 0) ? QUARTER : (QUARTER * ar) / al);
      default:            angle = (ar == 0) ? QUARTER : (QUARTER * al) / ar;
    endcase
    angle = angle % TURN;
    if (angle < 0) angle += TURN;
    res.drive_speed   = SPD_W'(speed);
    res.heading_angle = ANG_W'(angle);
    return res;
  endfunction

  always @(posedge clk) begin
    motion_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        motion_due.push_back(predict_motion(s_tdata[WHEEL_BITS-1:0],
                                            s_tdata[2*WHEEL_BITS-1:WHEEL_BITS]));
      if (m_tvalid && m_tready) begin
        if (motion_due.size() == 0) begin
          $error("result with no request outstanding: m_tdata %h", m_tdata);
          errs++;
        end else begin
          want = motion_due.pop_front();
          if (m_tdata[SPD_W-1:0] !== want.drive_speed) begin
            $error("drive_speed mismatch: expected %0d, got %0d",
                   want.drive_speed, m_tdata[SPD_W-1:0]);
            errs++;
          end
          if (m_tdata[SPD_W +: ANG_W] !== want.heading_angle) begin
            $error("heading_angle mismatch: expected %0d, got %0d",
                   want.heading_angle, m_tdata[SPD_W +: ANG_W]);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= motion_due.size();
  end

endmodule

// File: bench/testbench.sv
// top of the bench: clock, reset, wheel speed requests, receiver stalls and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WHEEL_BITS = 16;
  localparam int unsigned S_DATA_W   = ((2 * WHEEL_BITS + 7) / 8) * 8;
  localparam int          CYCLE_CAP  = 200000;  // far above the slowest clean run
  localparam int          HOLD_LEN   = 300;     // long receiver hold, fills the chain
  localparam int          SETTLE     = 60;      // settle margin after the last result

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [S_DATA_W-1:0]          s_tdata  = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [wsa_pkg::M_DATA_W-1:0] m_tdata;

  // shared between the request side and the receiver process
  logic quiet    = 1'b0;  // no idling on either side
  logic hold_req = 1'b0;  // asks the receiver for one long hold

  int fail_count;
  int pending;

  always #5 clk = ~clk;

  wheel_speeds_to_speed_angle_unit #(
    .WHEEL_BITS(WHEEL_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  motion_checker #(
    .WHEEL_BITS (WHEEL_BITS),
    .S_DATA_W   (S_DATA_W)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one request and hold it until the handshake edge; valid stays high
  // so a following request goes out back to back
  task automatic push_wheels(input logic signed [WHEEL_BITS-1:0] left,
                             input logic signed [WHEEL_BITS-1:0] right);
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left};
    do @(posedge clk); while (!s_tready);
  endtask

  // sender gap: valid low for a burst of cycles
  task automatic sender_gap(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [WHEEL_BITS-1:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  // random request drawn from several shapes so every motion class and the
  // wraparound of the heading get plenty of hits
  task automatic push_random();
    logic signed [WHEEL_BITS-1:0] l, r, tmp;
    int base;
    case ($urandom_range(0, 5))
      0: begin  // raw bits, covers every bit of both fields
        l = WHEEL_BITS'($urandom);
        r = WHEEL_BITS'($urandom);
      end
      1: begin  // small speeds, each within -1500..1500
        l = WHEEL_BITS'(int'($urandom_range(0, 3000)) - 1500);
        r = WHEEL_BITS'(int'($urandom_range(0, 3000)) - 1500);
      end
      2: begin  // tiny divisor, large pivot ratio and heading wrap
        l = WHEEL_BITS'($urandom_range(1, 8));
        if ($urandom_range(0, 1)) l = -l;
        r = WHEEL_BITS'($urandom);
      end
      3: begin  // one wheel stopped
        l = '0;
        r = WHEEL_BITS'($urandom);
      end
      4: begin  // both wheels the same way at similar speed
        base = $urandom_range(1, 32767);
        l = WHEEL_BITS'(base);
        r = WHEEL_BITS'(base + int'($urandom_range(0, 200)) - 100);
        if ($urandom_range(0, 1)) begin
          l = -l;
          r = -r;
        end
      end
      default: begin
        l = edge_value();
        r = edge_value();
      end
    endcase
    if ($urandom_range(0, 1)) begin
      tmp = l;
      l   = r;
      r   = tmp;
    end
    push_wheels(l, r);
  endtask

  // receiver: random stall bursts, one long hold on request, none when quiet
  initial begin : receiver
    int hold_left;
    int burst_left;
    logic hold_seen;
    hold_left  = 0;
    burst_left = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        m_tready <= 1'b0;
        burst_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready   <= 1'b0;
        burst_left = $urandom_range(1, 10) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, all four motion classes, zero divisors,
    // speed saturation and headings that need the modulo
    push_wheels(0, 0);
    push_wheels(32767, 32767);
    push_wheels(-32768, -32768);
    push_wheels(32767, -32768);
    push_wheels(-32768, 32767);
    push_wheels(0, -5);          // left pivot with stopped left wheel
    push_wheels(-5, 0);          // right pivot with stopped right wheel
    push_wheels(0, -32768);
    push_wheels(-32768, 0);
    push_wheels(100, 0);
    push_wheels(0, 100);
    push_wheels(-100, -100);
    push_wheels(-1, -32768);
    push_wheels(-32768, -1);
    push_wheels(1, -1);
    push_wheels(-1, 1);
    push_wheels(1000, -3);
    push_wheels(-3, 1000);
    push_wheels(1023, 1024);     // speed just at the cap
    push_wheels(1022, 1023);     // speed just under the cap
    push_wheels(-4, 1);          // heading of exactly a full turn
    push_wheels(-5, 1);
    push_wheels(1, -3);          // negative heading before the wrap
    push_wheels(1, -32768);
    push_wheels(-32768, 1);

    // sender pause until every result is back
    sender_gap(1);
    while (pending != 0) @(posedge clk);

    // long receiver hold while requests keep coming back to back
    hold_req <= 1'b1;
    repeat (60) push_random();

    // random part, idling bursts on both sides until the last stretch
    for (int n = 0; n < 870; n++) begin
      if (n == 720) quiet <= 1'b1;
      if (n < 720 && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 10));
      push_random();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/wsa_pkg.sv
hdl/wsa_prep.sv
hdl/wsa_cell.sv
hdl/wsa_out.sv
hdl/wheel_speeds_to_speed_angle_unit.sv
bench/motion_checker.sv
bench/testbench.sv
